// ===== design/qct_pkg.sv =====
// Shared types and constants for the quoted command tokenizer.
// Depends on nothing; imported by quoted_command_tokenizer_unit.
package qct_pkg;

  // Sizing constants
  localparam int BUF_BYTES  = 4096;
  localparam int MAX_TOKENS = 64;
  localparam int LINE_BYTES = 4096;

  localparam int CAP_W  = 13;  // argv_capacity register width
  localparam int ARGS_W = 7;   // max_args register / token count width
  localparam int ADDR_W = 12;  // buffer address width
  localparam int POS_W  = 12;  // line position width
  localparam int IDX_W  = 6;   // token index width
  localparam int CFG_W  = 13;  // config write data width

  // Configuration register indexes
  localparam logic CFG_ARGV_CAPACITY = 1'b0;
  localparam logic CFG_MAX_ARGS      = 1'b1;

  // Character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_SUMMARY   = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    MODE_GAP    = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_HALT   = 2'd3
  } scan_mode_t;

  typedef enum logic [1:0] {
    REST_IDLE  = 2'd0,
    REST_SEEK  = 2'd1,
    REST_FOUND = 2'd2
  } rest_search_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [ADDR_W-1:0] buf_addr;
    logic [7:0]        out_byte;
    logic [IDX_W-1:0]  token_index;
    logic              token_kept;
    logic [ARGS_W-1:0] token_count;
    logic [POS_W-1:0]  rest_offset;
    logic              last;
  } out_item_t;

endpackage

// ===== design/quoted_command_tokenizer_unit.sv =====
// Quoted command tokenizer: scan state, result queue and config registers.
// Depends on qct_pkg.
//
// A byte's first result is registered and visible in the cycle after its transaction.
// Throughput: one byte per cycle while out_ready is high and each byte yields at
//   most one result; a byte that yields more (up to 4) holds off the next byte.
// Reset (rst_n low, synchronous): scan state cleared, queue emptied,
//   argv_capacity = 4096, max_args = 64.
module quoted_command_tokenizer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  qct_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output qct_pkg::out_item_t           out_item,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [qct_pkg::CFG_W-1:0]    cfg_wdata
);
  import qct_pkg::*;

  // Config registers
  logic [CAP_W-1:0]  argv_capacity_r;
  logic [ARGS_W-1:0] max_args_r;

  // Scan state
  scan_mode_t        scan_mode_r, scan_mode_nxt;
  logic [ARGS_W-1:0] kept_tokens_r, kept_tokens_nxt;
  logic [CAP_W-1:0]  buffer_used_r, buffer_used_nxt;
  logic [CAP_W-1:0]  cur_len_r, cur_len_nxt;
  logic              overflowed_r, overflowed_nxt;
  logic [POS_W-1:0]  byte_pos_r, byte_pos_nxt;
  rest_search_t      rest_search_r, rest_search_nxt;
  logic [POS_W-1:0]  rest_found_r, rest_found_nxt;

  // Result queue
  out_item_t  queue_r [4];
  logic [2:0] queue_cnt_r;

  // Per-byte results
  out_item_t  res_v [4];
  logic [2:0] res_n_v;
  logic [1:0] last_idx_v;

  logic [CAP_W-1:0]  cap_v;
  logic [ARGS_W-1:0] limit_v;
  logic              sp_v;
  logic              put_b_v;
  logic              fin_v;
  logic [CAP_W:0]    addr1_v, addr2_v;
  logic              ok1_v, ok2_v;
  logic              keep_v;
  logic              accept;
  logic              pop;

  function automatic logic is_white(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) ||
           (b == CH_LF) || (b == CH_FF) || (b == CH_VT);
  endfunction

  function automatic out_item_t mk_item(input result_kind_t kind,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [7:0] data,
                                        input logic [IDX_W-1:0] idx,
                                        input logic kept,
                                        input logic [ARGS_W-1:0] count,
                                        input logic [POS_W-1:0] rest);
    out_item_t it;
    it.result_kind = kind;
    it.buf_addr    = addr;
    it.out_byte    = data;
    it.token_index = idx;
    it.token_kept  = kept;
    it.token_count = count;
    it.rest_offset = rest;
    it.last        = 1'b0;
    return it;
  endfunction

  // Handshakes: take a byte when the queue is empty or its last entry leaves now
  assign out_valid = (queue_cnt_r != 3'd0);
  assign out_item  = queue_r[0];
  assign pop       = out_valid && out_ready;
  assign in_ready  = (queue_cnt_r == 3'd0) || ((queue_cnt_r == 3'd1) && out_ready);
  assign accept    = in_valid && in_ready;

  // Effective limits
  assign cap_v   = (argv_capacity_r > CAP_W'(BUF_BYTES)) ? CAP_W'(BUF_BYTES)
                                                          : argv_capacity_r;
  assign limit_v = (max_args_r > ARGS_W'(MAX_TOKENS)) ? ARGS_W'(MAX_TOKENS) : max_args_r;

  // Next state and results for one byte: optional byte write, optional token
  // finish (terminator + token end), optional line summary, in that order.
  always_comb begin
    scan_mode_nxt   = scan_mode_r;
    kept_tokens_nxt = kept_tokens_r;
    buffer_used_nxt = buffer_used_r;
    cur_len_nxt     = cur_len_r;
    overflowed_nxt  = overflowed_r;
    byte_pos_nxt    = byte_pos_r;
    rest_search_nxt = rest_search_r;
    rest_found_nxt  = rest_found_r;
    res_n_v         = 3'd0;
    last_idx_v      = 2'd0;
    put_b_v         = 1'b0;
    fin_v           = 1'b0;
    addr1_v         = '0;
    addr2_v         = '0;
    ok1_v           = 1'b0;
    ok2_v           = 1'b0;
    keep_v          = 1'b0;
    for (int i = 0; i < 4; i++) begin
      res_v[i] = '0;
    end
    sp_v = is_white(in_item.in_byte);

    // First non-space after the first token
    if ((rest_search_r == REST_SEEK) && !sp_v) begin
      rest_found_nxt  = byte_pos_r;
      rest_search_nxt = REST_FOUND;
    end

    // Mode decision
    case (scan_mode_r)
      MODE_GAP: begin
        if (!sp_v) begin
          if (kept_tokens_r >= limit_v) begin
            scan_mode_nxt = MODE_HALT;
          end else begin
            cur_len_nxt    = '0;
            overflowed_nxt = 1'b0;
            if (in_item.in_byte == CH_QUOTE) begin
              scan_mode_nxt = MODE_QUOTED;
            end else begin
              scan_mode_nxt = MODE_PLAIN;
              put_b_v       = 1'b1;
            end
          end
        end
      end
      MODE_PLAIN: begin
        if (sp_v) fin_v = 1'b1;
        else      put_b_v = 1'b1;
      end
      MODE_QUOTED: begin
        if (in_item.in_byte == CH_QUOTE) fin_v = 1'b1;
        else                             put_b_v = 1'b1;
      end
      default: begin
      end
    endcase

    // Line end closes an open token
    if (in_item.line_end && !fin_v &&
        ((scan_mode_nxt == MODE_PLAIN) || (scan_mode_nxt == MODE_QUOTED))) begin
      fin_v = 1'b1;
    end

    // Byte write
    if (put_b_v && !overflowed_nxt) begin
      addr1_v = {1'b0, buffer_used_r} + {1'b0, cur_len_nxt};
      ok1_v   = (addr1_v < {1'b0, cap_v});
      if (ok1_v) begin
        res_v[res_n_v[1:0]] = mk_item(KIND_WRITE, addr1_v[ADDR_W-1:0], in_item.in_byte,
                                      kept_tokens_r[IDX_W-1:0], 1'b0, '0, '0);
        res_n_v     = res_n_v + 3'd1;
        cur_len_nxt = cur_len_nxt + CAP_W'(1);
      end else begin
        overflowed_nxt = 1'b1;
      end
    end

    // Token finish
    if (fin_v) begin
      if (!overflowed_nxt) begin
        addr2_v = {1'b0, buffer_used_r} + {1'b0, cur_len_nxt};
        ok2_v   = (addr2_v < {1'b0, cap_v});
        if (ok2_v) begin
          res_v[res_n_v[1:0]] = mk_item(KIND_WRITE, addr2_v[ADDR_W-1:0], 8'h00,
                                        kept_tokens_r[IDX_W-1:0], 1'b0, '0, '0);
          res_n_v     = res_n_v + 3'd1;
          cur_len_nxt = cur_len_nxt + CAP_W'(1);
        end else begin
          overflowed_nxt = 1'b1;
        end
      end
      keep_v = !overflowed_nxt;
      res_v[res_n_v[1:0]] = mk_item(KIND_TOKEN_END, buffer_used_r[ADDR_W-1:0], 8'h00,
                                    kept_tokens_r[IDX_W-1:0], keep_v, '0, '0);
      res_n_v = res_n_v + 3'd1;
      if (keep_v) begin
        buffer_used_nxt = buffer_used_r + cur_len_nxt;
        kept_tokens_nxt = kept_tokens_r + ARGS_W'(1);
        if (kept_tokens_r == '0) rest_search_nxt = REST_SEEK;
        scan_mode_nxt = MODE_GAP;
      end else begin
        scan_mode_nxt = MODE_HALT;
      end
      cur_len_nxt    = '0;
      overflowed_nxt = 1'b0;
    end

    // Line summary and clear, or advance the position
    if (in_item.line_end) begin
      res_v[res_n_v[1:0]] = mk_item(KIND_SUMMARY, '0, 8'h00, '0, 1'b0, kept_tokens_nxt,
                                    (rest_search_nxt == REST_FOUND) ? rest_found_nxt
                                                                    : POS_W'(0));
      res_n_v         = res_n_v + 3'd1;
      scan_mode_nxt   = MODE_GAP;
      kept_tokens_nxt = '0;
      buffer_used_nxt = '0;
      cur_len_nxt     = '0;
      overflowed_nxt  = 1'b0;
      byte_pos_nxt    = '0;
      rest_search_nxt = REST_IDLE;
      rest_found_nxt  = '0;
    end else if (byte_pos_r < POS_W'(LINE_BYTES - 1)) begin
      byte_pos_nxt = byte_pos_r + POS_W'(1);
    end

    // Mark the final result of this byte
    if (res_n_v != 3'd0) begin
      last_idx_v = res_n_v[1:0] - 2'd1;
      res_v[last_idx_v].last = 1'b1;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      argv_capacity_r <= CAP_W'(4096);
      max_args_r      <= ARGS_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARGV_CAPACITY: argv_capacity_r <= cfg_wdata[CAP_W-1:0];
        CFG_MAX_ARGS:      max_args_r      <= cfg_wdata[ARGS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Scan state registers, updated per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_mode_r   <= MODE_GAP;
      kept_tokens_r <= '0;
      buffer_used_r <= '0;
      cur_len_r     <= '0;
      overflowed_r  <= 1'b0;
      byte_pos_r    <= '0;
      rest_search_r <= REST_IDLE;
      rest_found_r  <= '0;
    end else if (accept) begin
      scan_mode_r   <= scan_mode_nxt;
      kept_tokens_r <= kept_tokens_nxt;
      buffer_used_r <= buffer_used_nxt;
      cur_len_r     <= cur_len_nxt;
      overflowed_r  <= overflowed_nxt;
      byte_pos_r    <= byte_pos_nxt;
      rest_search_r <= rest_search_nxt;
      rest_found_r  <= rest_found_nxt;
    end
  end

  // Result queue count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_cnt_r <= 3'd0;
    end else if (accept) begin
      queue_cnt_r <= res_n_v;
    end else if (pop) begin
      queue_cnt_r <= queue_cnt_r - 3'd1;
    end
  end

  // Result queue payload: load on a new byte, shift on each taken result
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        queue_r[i] <= res_v[i];
      end
    end else if (pop) begin
      for (int i = 0; i < 3; i++) begin
        queue_r[i] <= queue_r[i+1];
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Queue never holds more than one byte's worth of results
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queue_cnt_r <= 3'd4)
    else $error("result queue count out of range");

  // The last-marked result is always the tail of the queue
  a_last_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> (queue_cnt_r == 3'd1))
    else $error("last flag not on final queued result");

  // Line end returns the scan state to its start
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.line_end) |=>
      (kept_tokens_r == '0) && (buffer_used_r == '0) && (byte_pos_r == '0))
    else $error("line state not cleared after line end");

  // Kept tokens and buffer use stay within their limits
  a_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (kept_tokens_r <= ARGS_W'(MAX_TOKENS)) && (buffer_used_r <= CAP_W'(BUF_BYTES)))
    else $error("token count or buffer use beyond limit");

  // A summary is always the final result of its byte
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.result_kind == KIND_SUMMARY)) |-> out_item.last)
    else $error("summary not marked last");
`endif

endmodule
